// File: rtl/core/shader_source_lexer_macros.svh
// ---------------------------------------------------------------------------
// Shader source lexer assertion macros
// Concurrent property wrappers shared by the lexer RTL files.
// ---------------------------------------------------------------------------
`ifndef SHADER_SOURCE_LEXER_MACROS_SVH
`define SHADER_SOURCE_LEXER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define SSL_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lexer assertion failed");
// Next-cycle implication, disabled during reset.
`define SSL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lexer assertion failed");
`else
`define SSL_ASSERT_IMP(label, clk, rstn, ante, cons)
`define SSL_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/core/ssl_pkg.sv
// ---------------------------------------------------------------------------
// Shader source lexer package
// Token kinds, character codes, class decoders and the token record type.
// ---------------------------------------------------------------------------
package ssl_pkg;

    localparam logic [3:0] KIND_SPACE    = 4'd0;
    localparam logic [3:0] KIND_TAB      = 4'd1;
    localparam logic [3:0] KIND_NEWLINE  = 4'd2;
    localparam logic [3:0] KIND_COMMENT  = 4'd3;
    localparam logic [3:0] KIND_PUNCT    = 4'd4;
    localparam logic [3:0] KIND_OPERATOR = 4'd5;
    localparam logic [3:0] KIND_IDENT    = 4'd6;
    localparam logic [3:0] KIND_NUMBER   = 4'd7;
    localparam logic [3:0] KIND_OTHER_WS = 4'd8;

    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;

    // One token record. The top level packs it onto the result bus.
    typedef struct packed {
        logic        last;
        logic        has_decimal;
        logic [7:0]  token_char;
        logic [15:0] length;
        logic [15:0] start_column;
        logic [15:0] start_line;
        logic [3:0]  token_kind;
    } ssl_rec_t;

    // Records produced by one input beat; count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        ssl_rec_t   rec0;
        ssl_rec_t   rec1;
    } ssl_push_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c == 8'h2C) || (c == 8'h3B) || (c == 8'h28) || (c == 8'h29) ||
               (c == 8'h7B) || (c == 8'h7D) || (c == 8'h5B) || (c == 8'h5D);
    endfunction

    function automatic logic is_oper(input logic [7:0] c);
        return (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2A) || (c == 8'h2F) ||
               (c == 8'h25) || (c == 8'h3D) || (c == 8'h26) || (c == 8'h7C) ||
               (c == 8'h3C) || (c == 8'h3E) || (c == 8'h21);
    endfunction

endpackage

// File: rtl/core/ssl_lex_core.sv
// ---------------------------------------------------------------------------
// Shader source lexer core
// Holds the lexing mode and counters and turns one byte into zero to two
// token records in a single step.
// ---------------------------------------------------------------------------
`include "shader_source_lexer_macros.svh"

module ssl_lex_core
    import ssl_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] in_ch,
    input  logic       in_eos,
    output ssl_push_t  push
);

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_IDENT   = 3'd1;
    localparam logic [2:0] MODE_NUMBER  = 3'd2;
    localparam logic [2:0] MODE_COMMENT = 3'd3;
    localparam logic [2:0] MODE_SLASH   = 3'd4;

    logic [2:0]             mode_reg, mode_next;
    logic [COUNT_WIDTH-1:0] start_line_reg, start_line_next;
    logic [COUNT_WIDTH-1:0] start_col_reg, start_col_next;
    logic [COUNT_WIDTH-1:0] length_reg, length_next;
    logic [COUNT_WIDTH-1:0] line_cnt_reg, line_cnt_next;
    logic [COUNT_WIDTH-1:0] col_cnt_reg, col_cnt_next;
    logic                   dec_seen_reg, dec_seen_next;

    logic [COUNT_WIDTH-1:0] len_inc;
    logic [COUNT_WIDTH-1:0] flush_len;
    logic                   flush_en, disp_en;
    logic                   flush_emit, disp_emit;
    logic [3:0]             flush_kind;
    logic [3:0]             disp_kind;
    logic                   disp_opens;
    logic [2:0]             disp_mode;
    ssl_rec_t               flush_rec, disp_rec;

    // Counters may be narrower or wider than the 16-bit result fields.
    logic [COUNT_WIDTH+15:0] sl_ext, sc_ext, fl_ext, lc_ext, cc_ext;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == {COUNT_WIDTH{1'b1}}) ? v : v + COUNT_WIDTH'(1);
    endfunction

    assign len_inc = sat_inc(length_reg);

    // Decode a byte lexed from idle.
    always_comb begin
        disp_kind  = KIND_OTHER_WS;
        disp_opens = 1'b0;
        disp_mode  = MODE_IDLE;
        priority if (in_ch == CH_SPACE) begin
            disp_kind = KIND_SPACE;
        end else if (in_ch == CH_TAB) begin
            disp_kind = KIND_TAB;
        end else if (in_ch == CH_HASH) begin
            disp_opens = 1'b1;
            disp_mode  = MODE_COMMENT;
        end else if (in_ch == CH_SLASH) begin
            disp_opens = 1'b1;
            disp_mode  = MODE_SLASH;
        end else if (in_ch == CH_NEWLINE) begin
            disp_kind = KIND_NEWLINE;
        end else if (is_punct(in_ch)) begin
            disp_kind = KIND_PUNCT;
        end else if (is_oper(in_ch)) begin
            disp_kind = KIND_OPERATOR;
        end else if (is_ws(in_ch)) begin
            disp_kind = KIND_OTHER_WS;
        end else if (is_digit(in_ch)) begin
            disp_opens = 1'b1;
            disp_mode  = MODE_NUMBER;
        end else begin
            disp_opens = 1'b1;
            disp_mode  = MODE_IDENT;
        end
    end

    always_comb begin
        mode_next       = mode_reg;
        start_line_next = start_line_reg;
        start_col_next  = start_col_reg;
        length_next     = length_reg;
        line_cnt_next   = line_cnt_reg;
        col_cnt_next    = col_cnt_reg;
        dec_seen_next   = dec_seen_reg;
        flush_en        = 1'b0;
        disp_en         = 1'b0;
        flush_len       = (mode_reg == MODE_SLASH) ? COUNT_WIDTH'(1) : length_reg;

        if (in_eos) begin
            flush_en  = 1'b1;
            mode_next = MODE_IDLE;
        end else begin
            unique case (mode_reg)
                MODE_COMMENT: begin
                    length_next = len_inc;
                    if (in_ch == CH_NEWLINE) begin
                        // The newline belongs to the comment.
                        flush_en  = 1'b1;
                        flush_len = len_inc;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_SLASH: begin
                    if (in_ch == CH_SLASH) begin
                        mode_next   = MODE_COMMENT;
                        length_next = len_inc;
                    end else begin
                        flush_en = 1'b1;
                        disp_en  = 1'b1;
                    end
                end
                MODE_IDENT: begin
                    if (!is_ws(in_ch) && !is_punct(in_ch)) begin
                        length_next = len_inc;
                    end else begin
                        flush_en = 1'b1;
                        disp_en  = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit(in_ch) || (in_ch == CH_DOT)) begin
                        length_next = len_inc;
                        if (in_ch == CH_DOT) begin
                            dec_seen_next = 1'b1;
                        end
                    end else begin
                        flush_en = 1'b1;
                        disp_en  = 1'b1;
                    end
                end
                default: begin
                    disp_en = 1'b1;
                end
            endcase

            if (flush_en) begin
                mode_next = MODE_IDLE;
            end
            if (disp_en) begin
                mode_next = MODE_IDLE;
                if (disp_opens) begin
                    mode_next       = disp_mode;
                    start_line_next = line_cnt_reg;
                    start_col_next  = col_cnt_reg;
                    length_next     = COUNT_WIDTH'(1);
                    dec_seen_next   = 1'b0;
                end
            end

            if (in_ch == CH_NEWLINE) begin
                line_cnt_next = sat_inc(line_cnt_reg);
                col_cnt_next  = '0;
            end else begin
                col_cnt_next  = sat_inc(col_cnt_reg);
            end
        end
    end

    always_comb begin
        flush_kind = KIND_IDENT;
        flush_emit = 1'b0;
        unique case (mode_reg)
            MODE_IDENT: begin
                flush_kind = KIND_IDENT;
                flush_emit = flush_en;
            end
            MODE_NUMBER: begin
                flush_kind = KIND_NUMBER;
                flush_emit = flush_en;
            end
            MODE_COMMENT: begin
                flush_kind = KIND_COMMENT;
                flush_emit = flush_en;
            end
            MODE_SLASH: begin
                flush_kind = KIND_OPERATOR;
                flush_emit = flush_en;
            end
            default: begin
                flush_emit = 1'b0;
            end
        endcase
    end

    assign disp_emit = disp_en && !disp_opens;

    assign sl_ext = {16'd0, start_line_reg};
    assign sc_ext = {16'd0, start_col_reg};
    assign fl_ext = {16'd0, flush_len};
    assign lc_ext = {16'd0, line_cnt_reg};
    assign cc_ext = {16'd0, col_cnt_reg};

    always_comb begin
        flush_rec.token_kind   = flush_kind;
        flush_rec.start_line   = sl_ext[15:0];
        flush_rec.start_column = sc_ext[15:0];
        flush_rec.length       = fl_ext[15:0];
        flush_rec.token_char   = (mode_reg == MODE_SLASH) ? CH_SLASH : 8'd0;
        flush_rec.has_decimal  = (mode_reg == MODE_NUMBER) ? dec_seen_reg : 1'b0;
        flush_rec.last         = !disp_emit;

        disp_rec.token_kind    = disp_kind;
        disp_rec.start_line    = lc_ext[15:0];
        disp_rec.start_column  = cc_ext[15:0];
        disp_rec.length        = 16'd1;
        disp_rec.token_char    = in_ch;
        disp_rec.has_decimal   = 1'b0;
        disp_rec.last          = 1'b1;

        push.rec1 = disp_rec;
        if (flush_emit) begin
            push.rec0 = flush_rec;
        end else begin
            push.rec0 = disp_rec;
        end
        if (!step) begin
            push.count = 2'd0;
        end else begin
            push.count = {1'b0, flush_emit} + {1'b0, disp_emit};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_IDLE;
            start_line_reg <= '0;
            start_col_reg  <= '0;
            length_reg     <= '0;
            line_cnt_reg   <= '0;
            col_cnt_reg    <= '0;
            dec_seen_reg   <= 1'b0;
        end else if (step) begin
            mode_reg       <= mode_next;
            start_line_reg <= start_line_next;
            start_col_reg  <= start_col_next;
            length_reg     <= length_next;
            line_cnt_reg   <= line_cnt_next;
            col_cnt_reg    <= col_cnt_next;
            dec_seen_reg   <= dec_seen_next;
        end
    end

    `SSL_ASSERT_IMP(a_pair_order, aclk, aresetn, push.count == 2'd2, !push.rec0.last && push.rec1.last)
    `SSL_ASSERT_NEXT(a_eos_idle, aclk, aresetn, step && in_eos, mode_reg == MODE_IDLE)
    `SSL_ASSERT_IMP(a_mode_legal, aclk, aresetn, 1'b1, mode_reg <= MODE_SLASH)

endmodule

// File: rtl/core/ssl_out_fifo.sv
// ---------------------------------------------------------------------------
// Shader source lexer result queue
// Four-entry queue that takes up to two token records per cycle and
// presents one per beat on the result channel.
// ---------------------------------------------------------------------------
`include "shader_source_lexer_macros.svh"

module ssl_out_fifo
    import ssl_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  ssl_push_t push,
    output logic      room,
    output logic      out_valid,
    input  logic      out_ready,
    output ssl_rec_t  out_rec
);

    localparam int DEPTH = 4;

    ssl_rec_t   mem [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    // Room for a full pair of records, ignoring a pop in the same cycle.
    assign room      = count_reg <= 3'(DEPTH - 2);
    assign out_valid = count_reg != 3'd0;
    assign out_rec   = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    assign wr_ptr_next = wr_ptr_reg + push.count;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    assign count_next  = count_reg + {1'b0, push.count} - {2'b00, pop};

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.rec0;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_reg + 2'd1] <= push.rec1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `SSL_ASSERT_IMP(a_no_overflow, aclk, aresetn, push.count != 2'd0, count_reg <= 3'(DEPTH - 2))
    `SSL_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= 3'(DEPTH))
    `SSL_ASSERT_NEXT(a_drain_empty, aclk, aresetn, pop && (push.count == 2'd0) && (count_reg == 3'd1), !out_valid)

endmodule

// File: rtl/core/shader_source_lexer.sv
// ---------------------------------------------------------------------------
// Shader source lexer
// Character-class lexer that turns a byte stream into token records.
// ---------------------------------------------------------------------------
// The input channel carries one source byte per beat in s_axis_tdata; a beat
// with s_axis_tuser set marks end of stream, flushes any pending token and
// its byte is ignored. The result channel carries one token record per beat;
// m_axis_tlast marks the last record caused by one input beat. An input beat
// causes zero, one or two records. Identifiers and numbers are emitted when
// the byte after them (or end of stream) arrives, comments when their closing
// newline (or end of stream) arrives. An accepted beat waits in the input
// register until the queue has room; it is then lexed and its records are
// written into the result queue, which drives m_axis_tvalid from its count.
// One input beat is taken per cycle while results drain one per cycle; the
// four-entry result queue sets the pace, since the input stage waits until
// the queue has room for two records. When the receiver stalls, the queue
// fills and s_axis_tready drops; nothing is lost. Reset clears the mode,
// the line and column counters and the queue; no clearing pass is needed.
// ---------------------------------------------------------------------------
module shader_source_lexer
    import ssl_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic [0:0]  s_axis_tuser,   // [0] end_of_stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] token_kind, [19:4] start_line, [35:20] start_column,
    // [51:36] length, [59:52] token_char, [60] has_decimal, [63:61] zero
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    logic       in_valid_reg;
    logic [7:0] in_ch_reg;
    logic       in_eos_reg;
    logic       room;
    logic       step;
    ssl_push_t  push;
    ssl_rec_t   out_rec;

    assign step          = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_ch_reg  <= s_axis_tdata;
            in_eos_reg <= s_axis_tuser[0];
        end
    end

    ssl_lex_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_ch   (in_ch_reg),
        .in_eos  (in_eos_reg),
        .push    (push)
    );

    ssl_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_rec   (out_rec)
    );

    assign m_axis_tdata = {3'b000, out_rec.has_decimal, out_rec.token_char, out_rec.length,
                           out_rec.start_column, out_rec.start_line, out_rec.token_kind};
    assign m_axis_tlast = out_rec.last;

endmodule

// File: tb/shader_source_lexer_tb.sv
// ---------------------------------------------------------------------------
// Shader source lexer testbench
// Streams source bytes and end-of-stream beats into the lexer and checks
// every token record against an in-bench lexer that tracks the same mode,
// line, column and length state. A short directed sequence runs first, then
// random token streams under several sender and receiver idling patterns
// and a long receiver hold-off, then a last random stream closed by end of stream.
// ---------------------------------------------------------------------------
module shader_source_lexer_tb;
    import ssl_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int END_WAIT    = 20;
    localparam int PHASE_BEATS = 200;

    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_CR = 8'h0D;

    typedef enum logic [2:0] {
        LX_IDLE,
        LX_IDENT,
        LX_NUMBER,
        LX_COMMENT,
        LX_SLASH
    } lex_mode_t;

    typedef struct {
        logic [7:0] ch;
        logic       eos;
    } src_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] ch
    logic [0:0]  s_axis_tuser = 1'b0;    // [0] end_of_stream
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [3:0] token_kind, [19:4] start_line, [35:20] start_column,
    // [51:36] length, [59:52] token_char, [60] has_decimal, [63:61] zero
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;

    src_beat_t src_beats[$];
    ssl_rec_t  expected_tokens[$];
    ssl_rec_t  beat_tokens[$];
    int        beats_queued = 0;
    int        mismatches = 0;
    int        records_seen = 0;
    int        stall_cycles = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    logic      hold_active = 1'b0;
    int        hold_count;
    event      hold_go;

    // Lexer state as the block should hold it.
    lex_mode_t   lx_mode = LX_IDLE;
    logic [15:0] tok_line = '0;
    logic [15:0] tok_col = '0;
    logic [15:0] tok_len = '0;
    logic        tok_dot = 1'b0;
    logic [15:0] cur_line = '0;
    logic [15:0] cur_col = '0;

    shader_source_lexer DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 aclk = ~aclk;

    function automatic logic [15:0] sat16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic bit ch_is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic bit ch_is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic bit ch_is_punct(input logic [7:0] c);
        case (c)
            ",", ";", "(", ")", "{", "}", "[", "]": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit ch_is_oper(input logic [7:0] c);
        case (c)
            "+", "-", "*", "/", "%", "=", "&", "|", "<", ">", "!": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    task automatic add_token(input logic [3:0] kind, input logic [15:0] line,
                             input logic [15:0] col, input logic [15:0] len,
                             input logic [7:0] chr, input logic dec);
        ssl_rec_t rec;
        rec.token_kind   = kind;
        rec.start_line   = line;
        rec.start_column = col;
        rec.length       = len;
        rec.token_char   = chr;
        rec.has_decimal  = dec;
        rec.last         = 1'b0;
        beat_tokens = {beat_tokens, rec};
    endtask

    task automatic open_token(input lex_mode_t m);
        lx_mode  = m;
        tok_line = cur_line;
        tok_col  = cur_col;
        tok_len  = 16'd1;
        tok_dot  = 1'b0;
    endtask

    task automatic close_token();
        case (lx_mode)
            LX_IDENT:   add_token(KIND_IDENT, tok_line, tok_col, tok_len, 8'h00, 1'b0);
            LX_NUMBER:  add_token(KIND_NUMBER, tok_line, tok_col, tok_len, 8'h00, tok_dot);
            LX_COMMENT: add_token(KIND_COMMENT, tok_line, tok_col, tok_len, 8'h00, 1'b0);
            LX_SLASH:   add_token(KIND_OPERATOR, tok_line, tok_col, 16'd1, CH_SLASH, 1'b0);
            default: ;
        endcase
        lx_mode = LX_IDLE;
    endtask

    // Lexes one byte with nothing pending: single-byte tokens come out
    // at once, everything else opens a token.
    task automatic start_token(input logic [7:0] c);
        if (c == CH_SPACE) begin
            add_token(KIND_SPACE, cur_line, cur_col, 16'd1, c, 1'b0);
        end else if (c == CH_TAB) begin
            add_token(KIND_TAB, cur_line, cur_col, 16'd1, c, 1'b0);
        end else if (c == CH_HASH) begin
            open_token(LX_COMMENT);
        end else if (c == CH_SLASH) begin
            open_token(LX_SLASH);
        end else if (c == CH_NEWLINE) begin
            add_token(KIND_NEWLINE, cur_line, cur_col, 16'd1, c, 1'b0);
        end else if (ch_is_punct(c)) begin
            add_token(KIND_PUNCT, cur_line, cur_col, 16'd1, c, 1'b0);
        end else if (ch_is_oper(c)) begin
            add_token(KIND_OPERATOR, cur_line, cur_col, 16'd1, c, 1'b0);
        end else if (ch_is_ws(c)) begin
            add_token(KIND_OTHER_WS, cur_line, cur_col, 16'd1, c, 1'b0);
        end else if (ch_is_digit(c)) begin
            open_token(LX_NUMBER);
        end else begin
            open_token(LX_IDENT);
        end
    endtask

    task automatic lex_beat(input src_beat_t b);
        beat_tokens.delete();
        if (b.eos) begin
            close_token();
        end else begin
            case (lx_mode)
                LX_COMMENT: begin
                    tok_len = sat16(tok_len);
                    if (b.ch == CH_NEWLINE) close_token();
                end
                LX_SLASH: begin
                    if (b.ch == CH_SLASH) begin
                        lx_mode = LX_COMMENT;
                        tok_len = sat16(tok_len);
                    end else begin
                        close_token();
                        start_token(b.ch);
                    end
                end
                LX_IDENT: begin
                    if (!ch_is_ws(b.ch) && !ch_is_punct(b.ch)) begin
                        tok_len = sat16(tok_len);
                    end else begin
                        close_token();
                        start_token(b.ch);
                    end
                end
                LX_NUMBER: begin
                    if (ch_is_digit(b.ch) || (b.ch == CH_DOT)) begin
                        tok_len = sat16(tok_len);
                        if (b.ch == CH_DOT) tok_dot = 1'b1;
                    end else begin
                        close_token();
                        start_token(b.ch);
                    end
                end
                default: start_token(b.ch);
            endcase
            if (b.ch == CH_NEWLINE) begin
                cur_line = sat16(cur_line);
                cur_col  = '0;
            end else begin
                cur_col = sat16(cur_col);
            end
        end
        if (beat_tokens.size() != 0) begin
            beat_tokens[beat_tokens.size() - 1].last = 1'b1;
        end
        foreach (beat_tokens[i]) expected_tokens = {expected_tokens, beat_tokens[i]};
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        $display("record %0d: %s expected 0x%0h, got 0x%0h", records_seen, what, want, got);
    endtask

    // Driver: a beat on offer stays on offer until it is taken.
    always @(posedge aclk) begin : drive_proc
        logic fire;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            fire = s_axis_tvalid && s_axis_tready;
            if (fire) lex_beat(src_beats.pop_front());
            if (s_axis_tvalid && !fire) begin
            end else if (src_beats.size() != 0 &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= src_beats[0].ch;
                s_axis_tuser  <= src_beats[0].eos;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : monitor_proc
        ssl_rec_t got;
        ssl_rec_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tlast, m_axis_tdata[60:0]};
                if (m_axis_tdata[63:61] != 3'b000) begin
                    report_mismatch("pad bits", 0, m_axis_tdata[63:61]);
                end
                if (expected_tokens.size() == 0) begin
                    report_mismatch("unexpected record", 0, got.token_kind);
                end else begin
                    want = expected_tokens.pop_front();
                    if (got.token_kind != want.token_kind)
                        report_mismatch("token_kind", want.token_kind, got.token_kind);
                    if (got.start_line != want.start_line)
                        report_mismatch("start_line", want.start_line, got.start_line);
                    if (got.start_column != want.start_column)
                        report_mismatch("start_column", want.start_column, got.start_column);
                    if (got.length != want.length)
                        report_mismatch("length", want.length, got.length);
                    if (got.token_char != want.token_char)
                        report_mismatch("token_char", want.token_char, got.token_char);
                    if (got.has_decimal != want.has_decimal)
                        report_mismatch("has_decimal", want.has_decimal, got.has_decimal);
                    if (got.last != want.last)
                        report_mismatch("last", want.last, got.last);
                end
                records_seen++;
            end
            m_axis_tready <= !hold_active && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off, so the result queue fills and the input stalls.
    always begin : hold_proc
        @(hold_go);
        hold_active <= 1'b1;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge aclk);
        hold_active <= 1'b0;
    end

    always @(posedge aclk) begin : watchdog_proc
        if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_byte(input logic [7:0] c);
        src_beat_t b;
        b.ch  = c;
        b.eos = 1'b0;
        src_beats = {src_beats, b};
        beats_queued++;
    endtask

    task automatic push_eos();
        src_beat_t b;
        b.ch  = 8'($urandom_range(0, 255));
        b.eos = 1'b1;
        src_beats = {src_beats, b};
        beats_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    function automatic logic [7:0] pick_char(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    function automatic logic [7:0] ident_tail();
        logic [7:0] c;
        int         pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) return pick_char("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_");
        if (pick == 6) return pick_char("0123456789");
        if (pick == 7) return CH_HASH;
        if (pick == 8) return pick_char("+-*/%=&|<>!.");
        do c = 8'($urandom_range(0, 255));
        while (ch_is_ws(c) || ch_is_punct(c));
        return c;
    endfunction

    // One token's worth of bytes; most are well formed, a few are noise.
    task automatic push_random_token();
        int         pick;
        int         n;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            if ($urandom_range(0, 7) != 0)
                push_byte(pick_char("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_"));
            else
                push_byte(8'h80 + 8'($urandom_range(0, 127)));
            n = $urandom_range(0, 7);
            repeat (n) push_byte(ident_tail());
        end else if (pick < 35) begin
            push_byte(pick_char("0123456789"));
            n = $urandom_range(0, 5);
            repeat (n) push_byte(($urandom_range(0, 4) == 0) ? CH_DOT : pick_char("0123456789"));
        end else if (pick < 45) begin
            if ($urandom_range(0, 1) == 0) push_byte(CH_HASH);
            else push_text("//");
            n = $urandom_range(0, 8);
            repeat (n) begin
                do c = 8'($urandom_range(0, 255));
                while (c == CH_NEWLINE);
                push_byte(c);
            end
            if ($urandom_range(0, 9) == 0) push_eos();
            else push_byte(CH_NEWLINE);
        end else if (pick < 65) begin
            n = $urandom_range(0, 9);
            if (n < 4) push_byte(CH_SPACE);
            else if (n < 6) push_byte(CH_TAB);
            else if (n < 8) push_byte(CH_NEWLINE);
            else push_byte(CH_VT + 8'($urandom_range(0, 2)));
        end else if (pick < 75) begin
            push_byte(pick_char(",;(){}[]"));
        end else if (pick < 85) begin
            push_byte(pick_char("+-*%=&|<>!"));
        end else if (pick < 90) begin
            push_byte(CH_SLASH);
        end else if (pick < 97) begin
            push_byte(8'($urandom_range(0, 255)));
        end else begin
            push_eos();
        end
    endtask

    task automatic wait_drained();
        while (src_beats.size() != 0 || expected_tokens.size() != 0) @(negedge aclk);
    endtask

    task automatic run_random(input int send_pct, input int recv_pct, input int n);
        int first;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        first = beats_queued;
        while (beats_queued - first < n) push_random_token();
        wait_drained();
    endtask

    initial begin : stimulus_proc
        int first;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Extreme bytes as an identifier, every single-byte kind but newline, both
        // comment openers, a lone slash, a decimal number, and
        // end of stream with and without a pending token.
        push_byte(8'h00);
        push_byte(8'hFF);
        push_text(" x#\t12.5;#\n//\n/+");
        push_byte(CH_VT);
        push_byte(CH_CR);
        push_eos();
        push_eos();
        push_byte(CH_SLASH);
        push_eos();
        wait_drained();

        run_random(0, 0, PHASE_BEATS);
        run_random(84, 0, PHASE_BEATS);
        run_random(0, 84, PHASE_BEATS);
        run_random(12, 12, PHASE_BEATS);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        first = beats_queued;
        while (beats_queued - first < 80) push_random_token();
        -> hold_go;
        wait_drained();

        first = beats_queued;
        while (beats_queued - first < 40) push_random_token();
        push_eos();
        wait_drained();

        repeat (END_WAIT) @(negedge aclk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: shader_source_lexer.f
+incdir+rtl/core
rtl/core/ssl_pkg.sv
rtl/core/ssl_lex_core.sv
rtl/core/ssl_out_fifo.sv
rtl/core/shader_source_lexer.sv
tb/shader_source_lexer_tb.sv
